FILE: rtl/core/bpc_pkg.sv
`timescale 1ns / 1ps

package bpc_pkg;

  // calibration word width and datapath widths
  localparam int CAL_W      = 16;
  localparam int DT_W       = 25;
  localparam int TEMP_W     = 20;
  localparam int ACC_W      = 40;
  localparam int SENS_HALF_W = 20;
  localparam int PRES_W     = 32;
  localparam int CFG_IDX_W  = 3;

  // temperature constants in 0.01 C
  localparam int TEMP_BASE  = 2000;
  // distance from the 20.00 C knee down to the -15.00 C knee
  localparam int VLOW_GAP   = 3500;

  // pressure saturation limits
  localparam logic signed [PRES_W-1:0] PRES_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [PRES_W-1:0] PRES_MIN = 32'sh8000_0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C1 = 3'd0,
    CFG_C2 = 3'd1,
    CFG_C3 = 3'd2,
    CFG_C4 = 3'd3,
    CFG_C5 = 3'd4,
    CFG_C6 = 3'd5
  } bpc_cfg_idx_t;

  // calibration words as held in the register file
  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } bpc_cal_t;

  // compensated terms handed from the correction pipe to the pressure pipe
  typedef struct packed {
    logic                     vld;
    logic signed [TEMP_W-1:0] temp;
    logic signed [ACC_W-1:0]  off;
    logic signed [ACC_W-1:0]  sens;
  } bpc_comp_t;

endpackage

FILE: rtl/core/bpc_cfg_regs.sv
`timescale 1ns / 1ps

module bpc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpc_pkg::CAL_W-1:0]        cfg_wdata,
  output bpc_pkg::bpc_cal_t                cal_o
);

  bpc_pkg::bpc_cal_t cal_r;
  bpc_pkg::bpc_cal_t cal_nxt;

  // register decode, unused indexes are dropped
  always_comb begin
    cal_nxt = cal_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bpc_pkg::CFG_C1: cal_nxt.c1 = cfg_wdata;
        bpc_pkg::CFG_C2: cal_nxt.c2 = cfg_wdata;
        bpc_pkg::CFG_C3: cal_nxt.c3 = cfg_wdata;
        bpc_pkg::CFG_C4: cal_nxt.c4 = cfg_wdata;
        bpc_pkg::CFG_C5: cal_nxt.c5 = cfg_wdata;
        bpc_pkg::CFG_C6: cal_nxt.c6 = cfg_wdata;
        default: cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  assign cal_o = cal_r;

endmodule

FILE: rtl/core/bpc_comp.sv
`timescale 1ns / 1ps

module bpc_comp #(
  parameter int RAW_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [RAW_BITS-1:0] d1_i,
  input  logic [RAW_BITS-1:0] d2_i,
  input  bpc_pkg::bpc_cal_t   cal_i,
  output bpc_pkg::bpc_comp_t  comp_o,
  output logic [RAW_BITS-1:0] d1_o
);

  localparam int CalW   = bpc_pkg::CAL_W;
  localparam int DtW    = bpc_pkg::DT_W;
  localparam int TempW  = bpc_pkg::TEMP_W;
  localparam int AccW   = bpc_pkg::ACC_W;
  localparam int MulW   = DtW + CalW + 1;
  localparam int SqW    = 2 * DtW;
  localparam int T2Sh   = 31;
  localparam int T2W    = SqW - 1 - T2Sh;
  localparam int TempSh = 23;
  localparam int OffSh  = 7;
  localparam int SensSh = 8;
  localparam int Stages = 6;

  // valid bits and raw pressure travel alongside the stages
  logic [Stages-1:0]   vld_r;
  logic [Stages-1:0]   vld_nxt;
  logic [RAW_BITS-1:0] d1_r [Stages];

  assign vld_nxt = {vld_r[Stages-2:0], in_vld};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d1_r[0] <= d1_i;
    for (int i = 1; i < Stages; i++) begin
      d1_r[i] <= d1_r[i-1];
    end
  end

  // stage a: temperature difference
  logic signed [DtW-1:0] dt_r;
  logic signed [DtW-1:0] dt_nxt;

  assign dt_nxt = $signed({{(DtW-RAW_BITS){1'b0}}, d2_i})
                - $signed({1'b0, cal_i.c5, 8'h00});

  always_ff @(posedge clk) begin
    dt_r <= dt_nxt;
  end

  // stage b: products of dt with the coefficients and with itself
  logic signed [MulW-1:0] pt_r, po_r, ps_r;
  logic signed [MulW-1:0] pt_nxt, po_nxt, ps_nxt;
  logic signed [SqW-1:0]  pd_r, pd_nxt;

  always_comb begin
    pt_nxt = dt_r * $signed({1'b0, cal_i.c6});
    po_nxt = dt_r * $signed({1'b0, cal_i.c4});
    ps_nxt = dt_r * $signed({1'b0, cal_i.c3});
    pd_nxt = dt_r * dt_r;
  end

  always_ff @(posedge clk) begin
    pt_r <= pt_nxt;
    po_r <= po_nxt;
    ps_r <= ps_nxt;
    pd_r <= pd_nxt;
  end

  // stage c: first-order temperature, offset, sensitivity and knee flags
  logic signed [MulW-1:0]  pt_bias, po_bias, ps_bias;
  logic signed [TempW-1:0] a_nxt, b_nxt, temp1_c_nxt;
  logic signed [AccW-1:0]  off1_c_nxt, sens1_c_nxt;
  logic [T2W-1:0]          t2_c_nxt;

  logic signed [TempW-1:0] a_r, b_r, temp1_c_r;
  logic signed [AccW-1:0]  off1_c_r, sens1_c_r;
  logic [T2W-1:0]          t2_c_r;
  logic                    low_c_r, vlow_c_r;

  always_comb begin
    // truncation toward zero: bias negative values before the shift
    pt_bias = pt_r + $signed({{(MulW-TempSh){1'b0}}, {TempSh{pt_r[MulW-1]}}});
    po_bias = po_r + $signed({{(MulW-OffSh){1'b0}}, {OffSh{po_r[MulW-1]}}});
    ps_bias = ps_r + $signed({{(MulW-SensSh){1'b0}}, {SensSh{ps_r[MulW-1]}}});
    // a is temp minus 20.00 C, b is temp plus 15.00 C
    a_nxt       = TempW'(pt_bias >>> TempSh);
    temp1_c_nxt = a_nxt + TempW'(bpc_pkg::TEMP_BASE);
    b_nxt       = a_nxt + TempW'(bpc_pkg::VLOW_GAP);
    off1_c_nxt  = $signed(AccW'({cal_i.c2, 16'h0000})) + AccW'(po_bias >>> OffSh);
    sens1_c_nxt = $signed(AccW'({cal_i.c1, 15'h0000})) + AccW'(ps_bias >>> SensSh);
    t2_c_nxt    = pd_r[SqW-2:T2Sh];
  end

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    temp1_c_r <= temp1_c_nxt;
    off1_c_r  <= off1_c_nxt;
    sens1_c_r <= sens1_c_nxt;
    t2_c_r    <= t2_c_nxt;
    low_c_r   <= a_nxt[TempW-1];
    vlow_c_r  <= b_nxt[TempW-1];
  end

  // stage d: squares for the second-order terms
  logic signed [AccW-1:0]  sq_r, sq2_r, sq_nxt, sq2_nxt;
  logic signed [TempW-1:0] temp1_d_r;
  logic signed [AccW-1:0]  off1_d_r, sens1_d_r;
  logic [T2W-1:0]          t2_d_r;
  logic                    low_d_r, vlow_d_r;

  always_comb begin
    sq_nxt  = a_r * a_r;
    sq2_nxt = b_r * b_r;
  end

  always_ff @(posedge clk) begin
    sq_r      <= sq_nxt;
    sq2_r     <= sq2_nxt;
    temp1_d_r <= temp1_c_r;
    off1_d_r  <= off1_c_r;
    sens1_d_r <= sens1_c_r;
    t2_d_r    <= t2_c_r;
    low_d_r   <= low_c_r;
    vlow_d_r  <= vlow_c_r;
  end

  // stage e: second-order corrections, zero above 20.00 C
  logic signed [AccW-1:0]  sq5, sq2_7, sq2_11;
  logic signed [AccW-1:0]  off2_nxt, sens2_nxt, off2_r, sens2_r;
  logic [T2W-1:0]          t2g_nxt, t2g_r;
  logic signed [TempW-1:0] temp1_e_r;
  logic signed [AccW-1:0]  off1_e_r, sens1_e_r;

  always_comb begin
    sq5    = (sq_r <<< 2) + sq_r;
    sq2_7  = (sq2_r <<< 3) - sq2_r;
    sq2_11 = (sq2_r <<< 3) + (sq2_r <<< 1) + sq2_r;
    off2_nxt  = '0;
    sens2_nxt = '0;
    t2g_nxt   = '0;
    if (low_d_r) begin
      off2_nxt  = sq5 >>> 1;
      sens2_nxt = sq5 >>> 2;
      t2g_nxt   = t2_d_r;
      // extra term below -15.00 C
      if (vlow_d_r) begin
        off2_nxt  = (sq5 >>> 1) + sq2_7;
        sens2_nxt = (sq5 >>> 2) + (sq2_11 >>> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    off2_r    <= off2_nxt;
    sens2_r   <= sens2_nxt;
    t2g_r     <= t2g_nxt;
    temp1_e_r <= temp1_d_r;
    off1_e_r  <= off1_d_r;
    sens1_e_r <= sens1_d_r;
  end

  // stage f: apply corrections
  logic signed [TempW-1:0] temp_f_r, temp_f_nxt;
  logic signed [AccW-1:0]  off_f_r, sens_f_r, off_f_nxt, sens_f_nxt;

  always_comb begin
    temp_f_nxt = temp1_e_r - $signed({{(TempW-T2W){1'b0}}, t2g_r});
    off_f_nxt  = off1_e_r - off2_r;
    sens_f_nxt = sens1_e_r - sens2_r;
  end

  always_ff @(posedge clk) begin
    temp_f_r <= temp_f_nxt;
    off_f_r  <= off_f_nxt;
    sens_f_r <= sens_f_nxt;
  end

  assign comp_o.vld  = vld_r[Stages-1];
  assign comp_o.temp = temp_f_r;
  assign comp_o.off  = off_f_r;
  assign comp_o.sens = sens_f_r;
  assign d1_o        = d1_r[Stages-1];

endmodule

FILE: rtl/core/bpc_pres.sv
`timescale 1ns / 1ps

module bpc_pres #(
  parameter int RAW_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bpc_pkg::bpc_comp_t                    comp_i,
  input  logic [RAW_BITS-1:0]                   d1_i,
  output logic                                  out_vld,
  output logic signed [bpc_pkg::TEMP_W-1:0]     temp_o,
  output logic signed [bpc_pkg::PRES_W-1:0]     pres_o
);

  localparam int TempW  = bpc_pkg::TEMP_W;
  localparam int AccW   = bpc_pkg::ACC_W;
  localparam int HalfW  = bpc_pkg::SENS_HALF_W;
  localparam int PresW  = bpc_pkg::PRES_W;
  localparam int ProdW  = RAW_BITS + AccW;
  localparam int PartW  = RAW_BITS + HalfW;
  localparam int ProdSh = 21;
  localparam int PresSh = 15;
  localparam int Stages = 4;

  // valid bits and temperature ride along
  logic [Stages-1:0]       vld_r;
  logic [Stages-1:0]       vld_nxt;
  logic signed [TempW-1:0] temp_r [Stages];

  assign vld_nxt = {vld_r[Stages-2:0], comp_i.vld};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    temp_r[0] <= comp_i.temp;
    for (int i = 1; i < Stages; i++) begin
      temp_r[i] <= temp_r[i-1];
    end
  end

  // stage g: d1 times sensitivity as two partial products
  logic [PartW-1:0]        plo_r, plo_nxt;
  logic signed [PartW-1:0] phi_r, phi_nxt;
  logic signed [AccW-1:0]  off_g_r;

  always_comb begin
    plo_nxt = d1_i * comp_i.sens[HalfW-1:0];
    phi_nxt = $signed({1'b0, d1_i}) * $signed(comp_i.sens[AccW-1:HalfW]);
  end

  always_ff @(posedge clk) begin
    plo_r   <= plo_nxt;
    phi_r   <= phi_nxt;
    off_g_r <= comp_i.off;
  end

  // stage h: combine partial products
  logic signed [ProdW-1:0] prod_r, prod_nxt;
  logic signed [AccW-1:0]  off_h_r;

  assign prod_nxt = $signed({phi_r, {HalfW{1'b0}}})
                  + $signed({{(ProdW-PartW){1'b0}}, plo_r});

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    off_h_r <= off_g_r;
  end

  // stage i: scale by 2^-21 toward zero and remove offset
  logic signed [ProdW-1:0] prod_bias, q1_r, q1_nxt;

  always_comb begin
    prod_bias = prod_r + $signed({{(ProdW-ProdSh){1'b0}}, {ProdSh{prod_r[ProdW-1]}}});
    q1_nxt    = (prod_bias >>> ProdSh)
              - $signed({{(ProdW-AccW){off_h_r[AccW-1]}}, off_h_r});
  end

  always_ff @(posedge clk) begin
    q1_r <= q1_nxt;
  end

  // stage j: scale by 2^-15 toward zero and saturate
  logic signed [ProdW-1:0] q1_bias, p_full;
  logic                    p_ovf;
  logic signed [PresW-1:0] pres_r, pres_nxt;

  always_comb begin
    q1_bias = q1_r + $signed({{(ProdW-PresSh){1'b0}}, {PresSh{q1_r[ProdW-1]}}});
    p_full  = q1_bias >>> PresSh;
    p_ovf   = !((&p_full[ProdW-1:PresW-1]) || !(|p_full[ProdW-1:PresW-1]));
    if (p_ovf) begin
      pres_nxt = p_full[ProdW-1] ? bpc_pkg::PRES_MIN : bpc_pkg::PRES_MAX;
    end else begin
      pres_nxt = p_full[PresW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    pres_r <= pres_nxt;
  end

  assign out_vld = vld_r[Stages-1];
  assign temp_o  = temp_r[Stages-1];
  assign pres_o  = pres_r;

endmodule

FILE: rtl/core/barometer_pressure_compensation.sv
`timescale 1ns / 1ps

// barometric pressure compensation with second-order temperature correction
// input: a request is taken on a rising edge with start high and busy low;
//   in_raw_pressure_reading and in_raw_temperature_reading carry D1 and D2,
//   of which the low RAW_BITS bits are used
// config: cfg_we writes cfg_wdata to calibration word cfg_index (0..5 are
//   C1..C6, other indexes are ignored); write only while no request is in flight
// output: out_valid is high for one cycle with out_temperature_centi (0.01 C)
//   and out_pressure_pa (Pa, saturated to 32 bits signed)
// throughput: one request per cycle while busy is low; a ten-stage pipeline, six stages for
//   dt, first-order terms, squares and corrections, four for the 24x40
//   pressure multiply (two partial products), the two scaling steps and
//   saturation
// reset: synchronous; clears calibration words to zero and drops all requests
//   in flight; busy stays high until the first edge after reset is released
// the receiver cannot stall; each result is shown exactly once
module barometer_pressure_compensation #(
  parameter int RAW_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [23:0]                           in_raw_pressure_reading,
  input  logic [23:0]                           in_raw_temperature_reading,
  output logic                                  out_valid,
  output logic signed [bpc_pkg::TEMP_W-1:0]     out_temperature_centi,
  output logic signed [bpc_pkg::PRES_W-1:0]     out_pressure_pa,
  input  logic                                  cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bpc_pkg::CAL_W-1:0]             cfg_wdata
);

  bpc_pkg::bpc_cal_t  cal;
  bpc_pkg::bpc_comp_t comp;
  logic [RAW_BITS-1:0] d1_comp;
  logic                busy_r;
  logic                accept;

  // busy only while in reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // calibration words
  bpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cal_o     (cal)
  );

  // temperature and second-order correction pipe
  bpc_comp #(
    .RAW_BITS (RAW_BITS)
  ) u_comp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (accept),
    .d1_i   (in_raw_pressure_reading[RAW_BITS-1:0]),
    .d2_i   (in_raw_temperature_reading[RAW_BITS-1:0]),
    .cal_i  (cal),
    .comp_o (comp),
    .d1_o   (d1_comp)
  );

  // pressure multiply, scaling and saturation pipe
  bpc_pres #(
    .RAW_BITS (RAW_BITS)
  ) u_pres (
    .clk     (clk),
    .rst_n   (rst_n),
    .comp_i  (comp),
    .d1_i    (d1_comp),
    .out_vld (out_valid),
    .temp_o  (out_temperature_centi),
    .pres_o  (out_pressure_pa)
  );

endmodule
